FILE: rtl/core/box_blur_3x3_rgb_assert.svh
// Assertion helpers; expect clk and arst_n in scope.
`ifndef BOX_BLUR_3X3_RGB_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_ASSERT_SVH

// same-cycle implication
`define BBLUR_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBLUR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bblur_pkg.sv
package bblur_pkg;

	localparam int CFG_DW  = 11;
	localparam int CFG_IW  = 1;
	localparam int DIV_K   = 20;
	localparam int RECIP_W = 20;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} out_t;

	// one window column, top row first
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} wcol_t;

	typedef struct packed {
		logic       col_ok;
		logic [2:0] row_ok;
	} cell_ctl_t;

	typedef struct packed {
		logic [9:0] red;
		logic [9:0] green;
		logic [9:0] blue;
		logic [1:0] cnt;
	} csum_t;

	// ceil(2^DIV_K / (2n)); exact for dividends below 2^DIV_K / 18
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			4'd1: m = 20'd524288;
			4'd2: m = 20'd262144;
			4'd3: m = 20'd174763;
			4'd4: m = 20'd131072;
			4'd5: m = 20'd104858;
			4'd6: m = 20'd87382;
			4'd7: m = 20'd74899;
			4'd8: m = 20'd65536;
			4'd9: m = 20'd58255;
			default: m = 20'd524288;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/core/bblur_ram.sv
module bblur_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/bblur_cell.sv
module bblur_cell (
	input  logic                  clk,
	input  logic                  en,
	input  bblur_pkg::wcol_t      d,
	input  bblur_pkg::cell_ctl_t  ctl,
	output bblur_pkg::wcol_t      q,
	output bblur_pkg::csum_t      psum
);
	import bblur_pkg::*;

	wcol_t col_q;
	pix_t  px [3];

	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= d;
		end
	end

	assign q     = col_q;
	assign px[0] = col_q.top;
	assign px[1] = col_q.mid;
	assign px[2] = col_q.bot;

	// masked column sum
	always_comb begin
		psum = '0;
		for (int r = 0; r < 3; r++) begin
			if (ctl.col_ok && ctl.row_ok[r]) begin
				psum.red   = psum.red + 10'(px[r].red);
				psum.green = psum.green + 10'(px[r].green);
				psum.blue  = psum.blue + 10'(px[r].blue);
				psum.cnt   = psum.cnt + 2'd1;
			end
		end
	end

endmodule

FILE: rtl/core/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb: streaming 3x3 box blur over RGB pixels in raster order.
// Input channel in_valid/in_ready/in_data: one transaction per pixel; opcode
// flush drains the frame once all pixels are in (width+1 transactions).
// Output channel out_valid/out_ready/out_data: one transaction per blurred
// pixel, frame_end set on the last pixel of the frame.
// Config: cfg_we/cfg_idx/cfg_data write image_width (0) or image_height (1)
// while idle; values clamp to 1..MAX, and the frame restarts.
// Throughput: one transaction per cycle on both sides while not stalled. A
// transaction on the input yields the pixel one row and one column behind
// it; that result passes through the line store read, window column shift,
// sum stage and divide stage into the output register.
// The neighbor count divides through a reciprocal table and one multiply per channel.
// Reset: sizes go to 1024 (or MAX), position counters to zero; line stores
// are not cleared and need no startup pass.
// Stall: when the output register holds an untaken result and another
// result is behind it, the whole pipeline holds and in_ready drops.
`include "box_blur_3x3_rgb_assert.svh"

module box_blur_3x3_rgb #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bblur_pkg::in_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bblur_pkg::out_t                 out_data,
	input  logic                            cfg_we,
	input  logic [bblur_pkg::CFG_IW-1:0]    cfg_idx,
	input  logic [bblur_pkg::CFG_DW-1:0]    cfg_data
);
	import bblur_pkg::*;

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 2);
	localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
	localparam int SUM_W = 12;
	localparam int X_W   = SUM_W + 1;
	localparam int PW    = X_W + RECIP_W;

	function automatic logic [WW-1:0] clamp_w(input logic [CFG_DW-1:0] v);
		logic [WW-1:0] r;
		if (v == '0) begin
			r = WW'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = WW'(MAX_WIDTH);
		end else begin
			r = WW'(v);
		end
		return r;
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [CFG_DW-1:0] v);
		logic [HW-1:0] r;
		if (v == '0) begin
			r = HW'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			r = HW'(MAX_HEIGHT);
		end else begin
			r = HW'(v);
		end
		return r;
	endfunction

	// sizes and position
	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;

	// input side
	logic          accept, adv, out_free;
	logic          is_drain, drop, col0, wrap, emit0, last0;
	logic          crow_first, crow_last, cok0;
	logic [WW-1:0] col_inc;
	logic [HW-1:0] h_p1;
	pix_t          pix0;

	// stage 1: line store read
	logic          v_s1;
	pix_t          pix_s1;
	logic [CW-1:0] col_s1;
	logic          byp_s1, emit_s1, last_s1;
	logic [1:0]    rok_s1, cok_s1;
	pix_t          upper_rd, middle_rd, top_s1, mid_s1;
	logic          shift;

	// stage 2: window
	logic          v_s2, last_s2;
	logic [1:0]    rok_s2, cok_s2;
	wcol_t         cin [3];
	wcol_t         cq [3];
	csum_t         ps [3];
	cell_ctl_t     cctl [3];
	logic [SUM_W-1:0] sr, sg, sb;
	logic [3:0]    n_sum;

	// stage 3: rounded dividends
	logic          v_s3, last_s3;
	logic [X_W-1:0] xr_s3, xg_s3, xb_s3;
	logic [3:0]    n_s3;
	logic [PW-1:0] prod_r, prod_g, prod_b;

	// output register
	logic          out_valid_q;
	out_t          out_q;

	assign out_free = !out_valid_q || out_ready;
	assign adv      = out_free || !v_s3;
	assign in_ready = adv;
	assign accept   = in_valid && in_ready;

	assign is_drain   = (row_q >= h_q);
	assign drop       = !is_drain && (in_data.opcode == OP_FLUSH);
	assign col0       = (col_q == '0);
	assign col_inc    = WW'(col_q) + WW'(1);
	assign wrap       = (col_inc >= w_q);
	assign h_p1       = h_q + HW'(1);
	assign emit0      = col0 ? (row_q >= HW'(2)) : (row_q != '0);
	assign crow_first = col0 ? (row_q == HW'(2)) : (row_q == HW'(1));
	assign crow_last  = col0 ? (row_q == h_p1) : (row_q == h_q);
	assign last0      = col0 && (row_q == h_p1);
	assign cok0       = col0 ? (w_q != WW'(1)) : (col_q != CW'(1));
	assign pix0       = is_drain ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= WW'(W_RST);
			h_q   <= HW'(H_RST);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_IMAGE_WIDTH: begin
					w_q <= clamp_w(cfg_data);
				end
				CFG_IMAGE_HEIGHT: begin
					h_q <= clamp_h(cfg_data);
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept && !drop) begin
			if (last0) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + HW'(1);
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= accept && !drop;
				v_s2 <= v_s1 && emit_s1;
				v_s3 <= v_s2;
			end
			if (out_free) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// width-one rows read the address written on the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix0;
			col_s1  <= col_q;
			byp_s1  <= v_s1 && (col_s1 == col_q);
			emit_s1 <= emit0;
			last_s1 <= last0;
			rok_s1  <= {!crow_last, !crow_first};
			cok_s1  <= {!col0, cok0};
		end
	end

	assign shift  = adv && v_s1;
	assign top_s1 = byp_s1 ? cq[2].mid : upper_rd;
	assign mid_s1 = byp_s1 ? cq[2].bot : middle_rd;

	bblur_ram #(
		.WIDTH ($bits(pix_t)),
		.DEPTH (MAX_WIDTH)
	) u_upper (
		.clk   (clk),
		.we    (shift),
		.waddr (col_s1),
		.wdata (mid_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (upper_rd)
	);

	bblur_ram #(
		.WIDTH ($bits(pix_t)),
		.DEPTH (MAX_WIDTH)
	) u_middle (
		.clk   (clk),
		.we    (shift),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (middle_rd)
	);

	always_ff @(posedge clk) begin
		if (shift) begin
			last_s2 <= last_s1;
			rok_s2  <= rok_s1;
			cok_s2  <= cok_s1;
		end
	end

	assign cin[2]  = '{top: top_s1, mid: mid_s1, bot: pix_s1};
	assign cin[1]  = cq[2];
	assign cin[0]  = cq[1];
	assign cctl[0] = '{col_ok: cok_s2[0], row_ok: {rok_s2[1], 1'b1, rok_s2[0]}};
	assign cctl[1] = '{col_ok: 1'b1, row_ok: {rok_s2[1], 1'b1, rok_s2[0]}};
	assign cctl[2] = '{col_ok: cok_s2[1], row_ok: {rok_s2[1], 1'b1, rok_s2[0]}};

	for (genvar i = 0; i < 3; i++) begin : g_cell
		bblur_cell u_cell (
			.clk  (clk),
			.en   (shift),
			.d    (cin[i]),
			.ctl  (cctl[i]),
			.q    (cq[i]),
			.psum (ps[i])
		);
	end

	assign sr    = SUM_W'(ps[0].red) + SUM_W'(ps[1].red) + SUM_W'(ps[2].red);
	assign sg    = SUM_W'(ps[0].green) + SUM_W'(ps[1].green) + SUM_W'(ps[2].green);
	assign sb    = SUM_W'(ps[0].blue) + SUM_W'(ps[1].blue) + SUM_W'(ps[2].blue);
	assign n_sum = 4'(ps[0].cnt) + 4'(ps[1].cnt) + 4'(ps[2].cnt);

	// 2*S + n, later divided by 2n
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			xr_s3   <= {sr, 1'b0} + X_W'(n_sum);
			xg_s3   <= {sg, 1'b0} + X_W'(n_sum);
			xb_s3   <= {sb, 1'b0} + X_W'(n_sum);
			n_s3    <= n_sum;
			last_s3 <= last_s2;
		end
	end

	assign prod_r = PW'(xr_s3) * PW'(recip(n_s3));
	assign prod_g = PW'(xg_s3) * PW'(recip(n_s3));
	assign prod_b = PW'(xb_s3) * PW'(recip(n_s3));

	always_ff @(posedge clk) begin
		if (out_free && v_s3) begin
			out_q <= '{
				red_out:   prod_r[DIV_K +: 8],
				green_out: prod_g[DIV_K +: 8],
				blue_out:  prod_b[DIV_K +: 8],
				frame_end: last_s3
			};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BBLUR_ASSERT_IMP(a_stall_cause, !in_ready, out_valid && !out_ready && v_s3, "stall without blocked result")
	`BBLUR_ASSERT_NXT(a_last_restart, accept && !drop && last0 && !cfg_we, col_q == '0 && row_q == '0, "frame did not restart")
	`BBLUR_ASSERT_IMP(a_center_counted, v_s2, n_sum != '0, "empty neighborhood")

endmodule

FILE: verif/box_blur_3x3_rgb_checker.sv
`timescale 1ns / 1ps

module box_blur_3x3_rgb_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  bblur_pkg::in_t                   in_data,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  bblur_pkg::out_t                  out_data,
	input  logic                             cfg_we,
	input  logic [bblur_pkg::CFG_IW-1:0]     cfg_idx,
	input  logic [bblur_pkg::CFG_DW-1:0]     cfg_data,
	output int                               fail_count,
	output int                               pending,
	output int                               pixels_checked
);
	import bblur_pkg::*;

	localparam int MAX_DIM = 1024;

	logic [CFG_DW-1:0] width_reg;
	logic [CFG_DW-1:0] height_reg;
	pix_t line_up [MAX_DIM];
	pix_t line_mid [MAX_DIM];
	pix_t win [9];
	int unsigned in_col;
	int unsigned in_row;
	int unsigned out_pos;
	out_t blurred_q [$];
	int errs;
	int checked;

	function automatic int unsigned eff_dim(logic [CFG_DW-1:0] v);
		int unsigned d;
		d = 32'(v);
		if (d == 0) return 1;
		if (d > MAX_DIM) return MAX_DIM;
		return d;
	endfunction

	function automatic logic [7:0] mean8(int unsigned s, int unsigned n);
		return 8'((2 * s + n) / (2 * n));
	endfunction

	task automatic restart_frame();
		in_col = 0;
		in_row = 0;
		out_pos = 0;
	endtask

	task automatic blur_step(input in_t item, output bit emit, output out_t px);
		int unsigned w, h, col, lin, n, sr, sg, sb;
		int orow, ocol, r, c;
		pix_t cur, top, mid, v;
		emit = 1'b0;
		px = '0;
		w = eff_dim(width_reg);
		h = eff_dim(height_reg);
		cur = '0;
		// a flush inside the frame is dropped without touching state
		if (!(in_row < h && item.opcode == OP_FLUSH)) begin
			if (in_row < h) cur = {item.red_in, item.green_in, item.blue_in};
			col = in_col;
			top = line_up[col];
			mid = line_mid[col];
			line_up[col] = mid;
			line_mid[col] = cur;
			for (int k = 0; k < 3; k++) begin
				win[k * 3] = win[k * 3 + 1];
				win[k * 3 + 1] = win[k * 3 + 2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = cur;
			lin = in_row * w + col;
			in_col = col + 1;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (lin >= w + 1) begin
				if (col == 0) begin
					ocol = int'(w) - 1;
					orow = int'(in_row) - 3;
					if (in_col != 0) orow++;
				end else begin
					ocol = int'(col) - 1;
					orow = int'(in_row) - 1;
					if (in_col == 0) orow--;
				end
				sr = 0;
				sg = 0;
				sb = 0;
				n = 0;
				for (int dr = 0; dr < 3; dr++) begin
					for (int dc = 0; dc < 3; dc++) begin
						r = orow + dr - 1;
						c = ocol + dc - 1;
						if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w)) begin
							v = win[dr * 3 + dc];
							sr += 32'(v.red);
							sg += 32'(v.green);
							sb += 32'(v.blue);
							n++;
						end
					end
				end
				if (n == 0) n = 1;
				px.red_out = mean8(sr, n);
				px.green_out = mean8(sg, n);
				px.blue_out = mean8(sb, n);
				px.frame_end = (out_pos + 1 >= w * h);
				out_pos++;
				if (px.frame_end) restart_frame();
				emit = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t got;
		out_t want;
		bit emit;
		if (!arst_n) begin
			width_reg = CFG_DW'(MAX_DIM);
			height_reg = CFG_DW'(MAX_DIM);
			for (int i = 0; i < MAX_DIM; i++) begin
				line_up[i] = '0;
				line_mid[i] = '0;
			end
			for (int i = 0; i < 9; i++) win[i] = '0;
			restart_frame();
			blurred_q.delete();
			errs = 0;
			checked = 0;
			fail_count <= 0;
			pending <= 0;
			pixels_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = out_data;
				if (blurred_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("output transaction with no pixel due: rgb %h %h %h end %b",
							got.red_out, got.green_out, got.blue_out, got.frame_end);
				end else begin
					want = blurred_q.pop_front();
					if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
							got.blue_out !== want.blue_out || got.frame_end !== want.frame_end) begin
						errs++;
						if (errs <= 10)
							$display("pixel %0d: expected rgb %h %h %h end %b, got rgb %h %h %h end %b",
								checked, want.red_out, want.green_out, want.blue_out,
								want.frame_end, got.red_out, got.green_out, got.blue_out,
								got.frame_end);
					end
					checked++;
				end
			end
			if (cfg_we) begin
				if (cfg_idx == CFG_IMAGE_WIDTH) width_reg = cfg_data;
				else if (cfg_idx == CFG_IMAGE_HEIGHT) height_reg = cfg_data;
				restart_frame();
			end
			if (in_valid && in_ready) begin
				blur_step(in_data, emit, want);
				if (emit) blurred_q.push_back(want);
			end
			fail_count <= errs;
			pending <= blurred_q.size();
			pixels_checked <= checked;
		end
	end

endmodule

FILE: verif/box_blur_3x3_rgb_tb.sv
`timescale 1ns / 1ps

module box_blur_3x3_rgb_tb;
	import bblur_pkg::*;

	localparam int SETTLE = 8;
	localparam int RANDOM_ITEMS = 400;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	in_t               in_data;
	logic              out_valid;
	logic              out_ready;
	out_t              out_data;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_idx;
	logic [CFG_DW-1:0] cfg_data;

	int fail_count;
	int pending;
	int pixels_checked;

	bit idle_on;
	int unsigned cur_w;
	int unsigned cur_h;
	int stream_items;
	int frames_sent;
	int size_settings;

	box_blur_3x3_rgb dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data,
		.cfg_we, .cfg_idx, .cfg_data
	);

	box_blur_3x3_rgb_checker chk (
		.clk, .arst_n,
		.in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data,
		.cfg_we, .cfg_idx, .cfg_data,
		.fail_count, .pending, .pixels_checked
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// output side: random backpressure per transaction
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_on ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [7:0] chan(bit extreme);
		if (extreme) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic in_t pix(logic [23:0] rgb);
		return {OP_PIXEL, rgb};
	endfunction

	function automatic in_t pixel_item(bit extreme);
		return pix({chan(extreme), chan(extreme), chan(extreme)});
	endfunction

	function automatic in_t flush_item();
		return {OP_FLUSH, 24'($urandom)};
	endfunction

	task automatic send(input in_t item);
		int gap;
		gap = idle_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IW-1:0] idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_DW'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_size(input int unsigned w_raw, input int unsigned h_raw);
		wait_idle();
		cfg_write(CFG_IMAGE_WIDTH, w_raw);
		cfg_write(CFG_IMAGE_HEIGHT, h_raw);
		cur_w = (w_raw == 0) ? 1 : ((w_raw > 1024) ? 1024 : w_raw);
		cur_h = (h_raw == 0) ? 1 : ((h_raw > 1024) ? 1024 : h_raw);
		size_settings++;
	endtask

	// keep < frame size leaves the frame unfinished, no drain
	task automatic send_frame(input int unsigned keep, input bit noisy);
		int unsigned total;
		int unsigned pause_at;
		bit extreme;
		total = cur_w * cur_h;
		extreme = ($urandom_range(0, 5) == 0);
		pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : total;
		for (int unsigned i = 0; i < keep; i++) begin
			if (noisy && $urandom_range(0, 9) == 0) send(flush_item());
			if (i == pause_at) wait_idle();
			send(pixel_item(extreme));
			stream_items++;
		end
		if (keep >= total) begin
			for (int unsigned i = 0; i <= cur_w; i++) begin
				send($urandom_range(0, 1) ? flush_item() : pixel_item(1'b0));
				stream_items++;
			end
			frames_sent++;
		end
	endtask

	initial begin
		int unsigned w_raw;
		int unsigned h_raw;
		int guard;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		stream_items = 0;
		frames_sent = 0;
		size_settings = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2, full-scale values; leading flush is dropped
		set_size(2, 2);
		send(flush_item());
		send(pix(24'hFFFFFF));
		send(pix(24'h000000));
		send(pix(24'hFF00FF));
		send(pix(24'h00FF00));
		send(flush_item());
		send(pixel_item(1'b0));
		send(flush_item());

		// single pixel frame
		set_size(1, 1);
		send(pix(24'hFFFFFF));
		send(flush_item());
		send(flush_item());

		// one row, rounding half up on the corners
		set_size(3, 1);
		send(pix(24'h000001));
		send(pix(24'h000000));
		send(pix(24'h000001));
		repeat (4) send(flush_item());

		// zero width acts as one column
		set_size(0, 3);
		send(pix(24'hFFFFFF));
		send(pix(24'h000000));
		send(pix(24'hFFFFFF));
		send(flush_item());
		send(pixel_item(1'b0));

		// unfinished frame, dropped by the next size write
		set_size(3, 3);
		repeat (4) send(pixel_item(1'b0));

		w_raw = 4;
		h_raw = 3;
		set_size(w_raw, h_raw);
		stream_items = 0;
		while (stream_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(1, 8);
				h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
				set_size(w_raw, h_raw);
			end
			idle_on <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 11) == 0) begin
				send_frame($urandom_range(0, cur_w * cur_h - 1), 1'b1);
				set_size(w_raw, h_raw);
			end else begin
				send_frame(cur_w * cur_h, 1'b1);
			end
		end

		// largest sizes, including out-of-range values; frames left unfinished
		idle_on <= 1'b1;
		set_size(2047, 1);
		send_frame(40, 1'b0);
		set_size(1, 2047);
		send_frame(60, 1'b1);
		idle_on <= 1'b0;
		set_size(1024, 2);
		send_frame(30, 1'b0);

		in_valid <= 1'b0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending != 0 && guard < 50000);
		repeat (SETTLE) @(posedge clk);

		$display("%0d full frames over %0d size settings (1 to 1024 per side), %0d stream items",
			frames_sent, size_settings, stream_items);
		$display("%0d blurred pixels compared, %0d failures, %0d still due",
			pixels_checked, fail_count, pending);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
